@@ src/iac_pkg.sv @@
// ---------------------------------------------------------------------------
// iac_pkg
// Shared constants, types and word conversions for the indexed array core.
// ---------------------------------------------------------------------------
package iac_pkg;

  // storage sizing
  localparam int CAPACITY = 1024;
  localparam int WORD_W   = 32;

  // fixed field widths of the channels
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 11;

  // derived widths
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_FILL,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic [CNT_OUT_W-1:0]     count;
    logic                     status;
  } result_t;

  // input word to storage width: truncate or sign-extend
  function automatic logic [WORD_W-1:0] to_word(input logic signed [DATA_W-1:0] v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[WORD_W-1:0];
  endfunction

  // stored word to output width: sign-extend then truncate
  function automatic logic signed [DATA_W-1:0] from_word(input logic [WORD_W-1:0] w);
    logic signed [WORD_W-1:0] w_s;
    logic signed [63:0]       wide;
    w_s  = w;
    wide = 64'(w_s);
    return wide[DATA_W-1:0];
  endfunction

endpackage

@@ src/iac_if.sv @@
// ---------------------------------------------------------------------------
// iac_cmd_if / iac_rsp_if
// Valid/ready channels carrying commands into and results out of the core.
// ---------------------------------------------------------------------------
interface iac_cmd_if import iac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      op;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

interface iac_rsp_if import iac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic [CNT_OUT_W-1:0]     element_count;
  logic                     status;

  modport source (output valid, read_data, element_count, status, input ready);
  modport sink   (input valid, read_data, element_count, status, output ready);
endinterface

@@ src/iac_ram.sv @@
// ---------------------------------------------------------------------------
// iac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module iac_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/iac_ctrl.sv @@
// ---------------------------------------------------------------------------
// iac_ctrl
// Command sequencer: range checks, count upkeep, zero-fill and shift walks.
// ---------------------------------------------------------------------------
module iac_ctrl import iac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  iac_cmd_if.sink           cmd,
  input  logic              slot_free,
  input  logic [WORD_W-1:0] rd_data,
  output mem_req_t          mem,
  output result_t           res
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [ADDR_W-1:0]        ptr, ptr_next;
  logic [ADDR_W-1:0]        index_q, index_next;
  logic signed [DATA_W-1:0] data_q, data_next;
  logic                     bad_q, bad_next;

  logic              accept;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [ADDR_W-1:0] addr_in;
  logic              acc_bad;
  logic              put_grows;
  logic              remove_moves;
  logic              fill_last;
  logic              shift_more;

  assign accept  = cmd.valid && (state == ST_IDLE);
  assign idx_ext = CMP_W'(cmd.index);
  assign cnt_ext = CMP_W'(count);
  assign addr_in = ADDR_W'(cmd.index);

  always_comb begin
    unique case (cmd.op)
      OP_PUT:    acc_bad = (idx_ext >= CAP_CMP);
      OP_GET:    acc_bad = (idx_ext >= cnt_ext);
      OP_REMOVE: acc_bad = (idx_ext >= cnt_ext);
      OP_CLEAR:  acc_bad = 1'b0;
      default:   acc_bad = 1'b0;
    endcase
  end

  assign put_grows    = idx_ext > cnt_ext;
  assign remove_moves = (idx_ext + CMP_W'(1)) < cnt_ext;
  // zero-fill ends on the entry just below the written index
  assign fill_last    = ADDR_W'(ptr + ADDR_W'(1)) == index_q;
  // ptr holds the address read last cycle
  assign shift_more   = (CNT_W'(ptr) + CNT_W'(1)) < count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (acc_bad) begin
            state_next = ST_RESP;
          end else begin
            unique case (cmd.op)
              OP_PUT:    state_next = put_grows ? ST_FILL : ST_RESP;
              OP_GET:    state_next = ST_GET;
              OP_REMOVE: state_next = remove_moves ? ST_SHIFT : ST_RESP;
              OP_CLEAR:  state_next = ST_RESP;
              default:   state_next = ST_RESP;
            endcase
          end
        end
      end
      ST_GET:   state_next = slot_free ? ST_IDLE : ST_RESP;
      ST_FILL:  state_next = fill_last ? ST_RESP : ST_FILL;
      ST_SHIFT: state_next = shift_more ? ST_SHIFT : ST_RESP;
      ST_RESP:  state_next = slot_free ? ST_IDLE : ST_RESP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready    = (state == ST_IDLE);
    mem.wr_en    = 1'b0;
    mem.wr_addr  = addr_in;
    mem.wr_data  = to_word(cmd.value);
    mem.rd_en    = 1'b0;
    mem.rd_addr  = addr_in;
    res.valid    = 1'b0;
    res.data     = data_q;
    res.count    = CNT_OUT_W'(count);
    res.status   = bad_q;
    unique case (state)
      ST_IDLE: begin
        mem.wr_en = accept && !acc_bad && (cmd.op == OP_PUT);
        mem.rd_en = accept && !acc_bad &&
                    ((cmd.op == OP_GET) || ((cmd.op == OP_REMOVE) && remove_moves));
        if (cmd.op == OP_REMOVE) begin
          mem.rd_addr = ADDR_W'(addr_in + ADDR_W'(1));
        end
      end
      ST_GET: begin
        res.valid = slot_free;
        res.data  = from_word(rd_data);
      end
      ST_FILL: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = ptr;
        mem.wr_data = '0;
      end
      ST_SHIFT: begin
        // write trails read by two entries, so the ports never collide
        mem.wr_en   = 1'b1;
        mem.wr_addr = ADDR_W'(ptr - ADDR_W'(1));
        mem.wr_data = rd_data;
        mem.rd_en   = shift_more;
        mem.rd_addr = ADDR_W'(ptr + ADDR_W'(1));
      end
      ST_RESP: begin
        res.valid = slot_free;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_next = count;
    ptr_next   = ptr;
    index_next = index_q;
    data_next  = data_q;
    bad_next   = bad_q;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          index_next = addr_in;
          data_next  = '0;
          bad_next   = acc_bad;
          if (!acc_bad) begin
            unique case (cmd.op)
              OP_PUT: begin
                if (put_grows) begin
                  ptr_next = ADDR_W'(count);
                end else if (idx_ext == cnt_ext) begin
                  count_next = CNT_W'(idx_ext) + CNT_W'(1);
                end
              end
              OP_GET: begin
              end
              OP_REMOVE: begin
                if (remove_moves) begin
                  ptr_next = ADDR_W'(addr_in + ADDR_W'(1));
                end else begin
                  count_next = count - CNT_W'(1);
                end
              end
              OP_CLEAR: count_next = '0;
              default: begin
              end
            endcase
          end
        end
      end
      ST_GET: data_next = from_word(rd_data);
      ST_FILL: begin
        ptr_next = ADDR_W'(ptr + ADDR_W'(1));
        if (fill_last) begin
          count_next = CNT_W'(index_q) + CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        if (shift_more) begin
          ptr_next = ADDR_W'(ptr + ADDR_W'(1));
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    index_q <= index_next;
    data_q  <= data_next;
    bad_q   <= bad_next;
  end

endmodule

@@ src/indexed_array_with_compaction_core.sv @@
// ---------------------------------------------------------------------------
// indexed_array_with_compaction_core
// Bounded array of signed words with put, get, remove-and-compact and clear.
// ---------------------------------------------------------------------------
//  channel  role    payload
//  cmd      sink    op, index, value
//  rsp      source  read_data, element_count, status
//
//  get, clear, in-place put and any flagged item: accept, then respond
//  growing put: zero-fill from count up to index, one zero written per cycle
//  remove: shift the entries above index down, one entry moved per cycle through
//  the single read and single write port of the array memory
//  rst (synchronous) empties the array and drops any held result; the array
//  memory is not cleared. a held result on rsp does not block the next
//  transfer on cmd; a second result waits until the first is taken
// ---------------------------------------------------------------------------
module indexed_array_with_compaction_core import iac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  iac_cmd_if.sink   cmd,
  iac_rsp_if.source rsp
);

  mem_req_t          mem;
  result_t           res;
  logic [WORD_W-1:0] rd_data;
  logic              slot_free;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [CNT_OUT_W-1:0]     out_count;
  logic                     out_status;

  iac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .slot_free (slot_free),
    .rd_data   (rd_data),
    .mem       (mem),
    .res       (res)
  );

  iac_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data   <= res.data;
      out_count  <= res.count;
      out_status <= res.status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_data;
  assign rsp.element_count = out_count;
  assign rsp.status        = out_status;

  a_ports_apart: assert property (@(posedge clk) disable iff (rst)
    (mem.wr_en && mem.rd_en) |-> (mem.wr_addr != mem.rd_addr))
    else $error("array write and read hit the same entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || rsp.ready))
    else $error("result loaded over a held result");

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> !res.valid)
    else $error("result produced in the cycle of a cmd transfer");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status) |-> (res.data == '0))
    else $error("flagged result carries nonzero data");

endmodule
